>>> design/dif_pkg.sv
package dif_pkg;

    // fixed field widths
    localparam int MAG_W      = 64;
    localparam int MINCNT_W   = 6;
    localparam int CHAR_W     = 8;
    localparam int TLEN_W     = 6;

    // decimal conversion sizes
    localparam int MAX_DIGITS = 20;
    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
    localparam int BITCNT_W   = $clog2(MAG_W);
    localparam int LEN_W      = 7;

    // default pad saturation
    localparam int MAX_PAD_DIGITS_DEF = 32;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

    // mod-3 position of the top digit when all digits are present
    localparam logic [1:0] MOD3_INIT = 2'(MAX_DIGITS % 3);

    // converted value handed from converter to emitter
    typedef struct packed {
        logic [BCD_W-1:0]  bcd;
        logic [NDIG_W-1:0] ndig;
        logic [1:0]        mod3;
    } t_conv_res;

    // step a mod-3 counter down by one
    function automatic logic [1:0] mod3_dec(input logic [1:0] m);
        return (m == 2'd0) ? 2'd2 : m - 2'd1;
    endfunction

endpackage

>>> design/dif_bcd_conv.sv
module dif_bcd_conv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dif_pkg::MAG_W-1:0]   i_magnitude,
    output logic                        o_idle,
    output logic                        o_done,
    output dif_pkg::t_conv_res          o_res
);
    import dif_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_NORM  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [MAG_W-1:0]    r_bin, n_bin;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    logic [BITCNT_W-1:0] r_cnt, n_cnt;
    logic [NDIG_W-1:0]   r_ndig, n_ndig;
    logic [1:0]          r_mod3, n_mod3;
    logic [BCD_W-1:0]    adj;
    logic                norm_stop;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        logic [3:0] d;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            d = r_bcd[4*k +: 4];
            adj[4*k +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    assign norm_stop = (r_bcd[BCD_W-1 -: 4] != 4'd0) || (r_ndig == NDIG_W'(1));

    // shift in one bit a cycle, then drop leading zero digits one a cycle
    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_ndig  = r_ndig;
        n_mod3  = r_mod3;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_bin   = i_magnitude;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_bcd = {adj[BCD_W-2:0], r_bin[MAG_W-1]};
                n_bin = {r_bin[MAG_W-2:0], 1'b0};
                n_cnt = r_cnt + BITCNT_W'(1);
                if (r_cnt == BITCNT_W'(MAG_W - 1)) begin
                    n_ndig  = NDIG_W'(MAX_DIGITS);
                    n_mod3  = MOD3_INIT;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (norm_stop) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig = r_ndig - NDIG_W'(1);
                    n_mod3 = mod3_dec(r_mod3);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_ndig <= n_ndig;
        r_mod3 <= n_mod3;
    end

    assign o_idle     = (r_state == S_IDLE);
    assign o_res.bcd  = r_bcd;
    assign o_res.ndig = r_ndig;
    assign o_res.mod3 = r_mod3;

endmodule

>>> design/dif_emit.sv
module dif_emit #(
    parameter int MAX_PAD_DIGITS = dif_pkg::MAX_PAD_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  dif_pkg::t_conv_res            i_res,
    input  logic                          i_negative,
    input  logic [dif_pkg::MINCNT_W-1:0]  i_min_digit_count,
    input  logic                          i_group_thousands,
    output logic                          o_idle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dif_pkg::CHAR_W-1:0]    o_character,
    output logic                          o_last_char,
    output logic [dif_pkg::TLEN_W-1:0]    o_total_length
);
    import dif_pkg::*;

    logic [LEN_W-1:0]    r_left;
    logic [LEN_W-1:0]    r_len;
    logic [MINCNT_W-1:0] r_pad;
    logic                r_sign;
    logic                r_grp;
    logic                r_first;
    logic                r_comma_done;
    logic [BCD_W-1:0]    r_bcd;
    logic [NDIG_W-1:0]   r_ndig;
    logic [1:0]          r_mod3;
    logic                r_ovalid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;
    logic [TLEN_W-1:0]   r_tlen;

    logic [MINCNT_W-1:0] want_sat;
    logic [MINCNT_W-1:0] pad;
    logic [NDIG_W-1:0]   commas;
    logic [NDIG_W+3:0]   comma_prod;
    logic [LEN_W-1:0]    len;
    logic                step;
    logic                put_comma;

    // length of the rendering from the converted digit count
    always_comb begin
        want_sat = (i_min_digit_count > MINCNT_W'(MAX_PAD_DIGITS))
                   ? MINCNT_W'(MAX_PAD_DIGITS) : i_min_digit_count;
        pad = '0;
        if (!i_group_thousands && (want_sat > MINCNT_W'(i_res.ndig))) begin
            pad = want_sat - MINCNT_W'(i_res.ndig);
        end
        // (ndig-1)/3 by reciprocal, exact for up to twenty digits
        comma_prod = (NDIG_W+4)'(i_res.ndig - NDIG_W'(1)) * (NDIG_W+4)'(11);
        commas = i_group_thousands ? NDIG_W'(comma_prod[NDIG_W+3:5]) : '0;
        len = LEN_W'(i_negative) + LEN_W'(pad) + LEN_W'(i_res.ndig) + LEN_W'(commas);
    end

    assign step      = (r_left != '0) && (!r_ovalid || i_ready);
    assign put_comma = r_grp && !r_first && (r_mod3 == 2'd0) && !r_comma_done;

    // one character per transfer: sign, pad zeros, then digits and commas
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_load) begin
                r_left       <= len;
                r_len        <= len;
                r_pad        <= pad;
                r_sign       <= i_negative;
                r_grp        <= i_group_thousands;
                r_first      <= 1'b1;
                r_comma_done <= 1'b0;
                r_bcd        <= i_res.bcd;
                r_ndig       <= i_res.ndig;
                r_mod3       <= i_res.mod3;
            end else if (step) begin
                r_left <= r_left - LEN_W'(1);
                if (r_sign) begin
                    r_sign <= 1'b0;
                end else if (r_pad != '0) begin
                    r_pad <= r_pad - MINCNT_W'(1);
                end else if (put_comma) begin
                    r_comma_done <= 1'b1;
                end else begin
                    r_bcd        <= {r_bcd[BCD_W-5:0], 4'd0};
                    r_ndig       <= r_ndig - NDIG_W'(1);
                    r_mod3       <= mod3_dec(r_mod3);
                    r_first      <= 1'b0;
                    r_comma_done <= 1'b0;
                end
            end
            if (step) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (step) begin
            r_last <= (r_left == LEN_W'(1));
            r_tlen <= r_len[TLEN_W-1:0];
            if (r_sign) begin
                r_char <= CH_MINUS;
            end else if (r_pad != '0) begin
                r_char <= CH_ZERO;
            end else if (put_comma) begin
                r_char <= CH_COMMA;
            end else begin
                r_char <= CH_ZERO + CHAR_W'(r_bcd[BCD_W-1 -: 4]);
            end
        end
    end

    assign o_idle         = (r_left == '0);
    assign o_valid        = r_ovalid;
    assign o_character    = r_char;
    assign o_last_char    = r_last;
    assign o_total_length = r_tlen;

    // a new number only starts once the previous one is fully issued
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_left == '0))
        else $error("load while characters remain");

    // the final character is always the last digit
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_left == LEN_W'(1)) |-> (r_ndig == NDIG_W'(1) && r_pad == '0 && !r_sign))
        else $error("final character is not the last digit");

    // digits remain for as long as characters remain
    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0 && !i_load) |-> (r_ndig != '0))
        else $error("characters left but no digits");

endmodule

>>> design/decimal_integer_formatter_top.sv
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// input    | i_valid / o_ready    | i_magnitude, i_negative, i_min_digit_count,
//          |                      | i_group_thousands
// output   | o_valid / i_ready    | o_character, o_last_char, o_total_length
//
// a number is converted bit-serially in the shift-add-3 register, then leading zero digits
// are dropped one per cycle (up to 19) before the result is handed to the emitter, which
// then issues one character per cycle while the output is not stalled.
// the next number is taken once every character of the current one has been issued;
// the final character may still sit in the output register at that time.
// reset is synchronous and active low; it clears only control state.
// a stalled output holds the character and pauses the emitter.
module decimal_integer_formatter_top #(
    parameter int MAX_PAD_DIGITS = dif_pkg::MAX_PAD_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dif_pkg::MAG_W-1:0]     i_magnitude,
    input  logic                          i_negative,
    input  logic [dif_pkg::MINCNT_W-1:0]  i_min_digit_count,
    input  logic                          i_group_thousands,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dif_pkg::CHAR_W-1:0]    o_character,
    output logic                          o_last_char,
    output logic [dif_pkg::TLEN_W-1:0]    o_total_length
);
    import dif_pkg::*;

    logic                r_negative;
    logic [MINCNT_W-1:0] r_min_digit_count;
    logic                r_group_thousands;
    logic                conv_idle;
    logic                conv_done;
    logic                emit_idle;
    logic                accept;
    t_conv_res           conv_res;

    assign o_ready = conv_idle && emit_idle;
    assign accept  = i_valid && o_ready;

    // hold the formatting options while the value converts
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_negative        <= i_negative;
            r_min_digit_count <= i_min_digit_count;
            r_group_thousands <= i_group_thousands;
        end
    end

    // binary to bcd converter
    dif_bcd_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_magnitude (i_magnitude),
        .o_idle      (conv_idle),
        .o_done      (conv_done),
        .o_res       (conv_res)
    );

    // character emitter
    dif_emit #(
        .MAX_PAD_DIGITS (MAX_PAD_DIGITS)
    ) u_emit (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (conv_done),
        .i_res             (conv_res),
        .i_negative        (r_negative),
        .i_min_digit_count (r_min_digit_count),
        .i_group_thousands (r_group_thousands),
        .o_idle            (emit_idle),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_character       (o_character),
        .o_last_char       (o_last_char),
        .o_total_length    (o_total_length)
    );

endmodule

>>> tb/decimal_text_checker.sv
module decimal_text_checker #(
    parameter int MAX_PAD_DIGITS = dif_pkg::MAX_PAD_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [dif_pkg::MAG_W-1:0]     i_magnitude,
    input  logic                          i_negative,
    input  logic [dif_pkg::MINCNT_W-1:0]  i_min_digit_count,
    input  logic                          i_group_thousands,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [dif_pkg::CHAR_W-1:0]    i_character,
    input  logic                          i_last_char,
    input  logic [dif_pkg::TLEN_W-1:0]    i_total_length,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import dif_pkg::*;

    // one expected character of the rendered text
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [TLEN_W-1:0] tlen;
    } char_rec_t;

    char_rec_t expected_chars[$];
    int        fails = 0;
    int        checked = 0;

    // render one number as decimal text and queue its characters
    function automatic void render_number(logic [MAG_W-1:0] mag, logic neg,
                                          logic [MINCNT_W-1:0] cnt, logic grp);
        logic [CHAR_W-1:0] digs[$];
        logic [CHAR_W-1:0] text[$];
        logic [MAG_W-1:0]  v;
        int                want;
        int                lead;
        int                pos;
        char_rec_t         rec;
        v = mag;
        do begin
            digs.push_front(CH_ZERO + CHAR_W'(v % 10));
            v = v / 10;
        end while (v != 0);
        // pad count saturates
        want = (int'(cnt) > MAX_PAD_DIGITS) ? MAX_PAD_DIGITS : int'(cnt);
        if (neg)
            text.push_back(CH_MINUS);
        if (!grp) begin
            for (int i = digs.size(); i < want; i++)
                text.push_back(CH_ZERO);
            foreach (digs[i])
                text.push_back(digs[i]);
        end else begin
            // leading group holds one to three digits, then comma-separated triples
            lead = ((digs.size() - 1) % 3) + 1;
            pos  = 0;
            for (int i = 0; i < lead; i++) begin
                text.push_back(digs[pos]);
                pos++;
            end
            while (pos < digs.size()) begin
                text.push_back(CH_COMMA);
                for (int i = 0; i < 3 && pos < digs.size(); i++) begin
                    text.push_back(digs[pos]);
                    pos++;
                end
            end
        end
        foreach (text[i]) begin
            rec.ch   = text[i];
            rec.last = (i == text.size() - 1);
            rec.tlen = TLEN_W'(text.size());
            expected_chars.push_back(rec);
        end
    endfunction

    // watch both channels, predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        char_rec_t exp_rec;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("character 0x%02h transferred with nothing expected", i_character);
                    fails++;
                end else begin
                    exp_rec = expected_chars.pop_front();
                    checked++;
                    if (i_character !== exp_rec.ch) begin
                        $error("character: expected 0x%02h, actual 0x%02h",
                               exp_rec.ch, i_character);
                        fails++;
                    end
                    if (i_last_char !== exp_rec.last) begin
                        $error("last_char: expected %0b, actual %0b",
                               exp_rec.last, i_last_char);
                        fails++;
                    end
                    if (i_total_length !== exp_rec.tlen) begin
                        $error("total_length: expected %0d, actual %0d",
                               exp_rec.tlen, i_total_length);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                render_number(i_magnitude, i_negative, i_min_digit_count,
                              i_group_thousands);
        end
        o_fail_count    <= fails;
        o_pending       <= expected_chars.size();
        o_chars_checked <= checked;
    end

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dif_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 100;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 120;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [MAG_W-1:0]    i_magnitude;
    logic                i_negative;
    logic [MINCNT_W-1:0] i_min_digit_count;
    logic                i_group_thousands;
    logic                o_valid;
    logic                i_ready;
    logic [CHAR_W-1:0]   o_character;
    logic                o_last_char;
    logic [TLEN_W-1:0]   o_total_length;

    int fail_count;
    int pending_chars;
    int chars_checked;
    int numbers_sent = 0;
    int directed_sent = 0;
    int burst_left = 4;
    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    decimal_integer_formatter_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_magnitude       (i_magnitude),
        .i_negative        (i_negative),
        .i_min_digit_count (i_min_digit_count),
        .i_group_thousands (i_group_thousands),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_character       (o_character),
        .o_last_char       (o_last_char),
        .o_total_length    (o_total_length)
    );

    decimal_text_checker u_text_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_ready        (o_ready),
        .i_magnitude       (i_magnitude),
        .i_negative        (i_negative),
        .i_min_digit_count (i_min_digit_count),
        .i_group_thousands (i_group_thousands),
        .i_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .i_character       (o_character),
        .i_last_char       (o_last_char),
        .i_total_length    (o_total_length),
        .o_fail_count      (fail_count),
        .o_pending         (pending_chars),
        .o_chars_checked   (chars_checked)
    );

    // offer one number and hold it until the transfer, gaps between bursts
    task automatic send_number(logic [MAG_W-1:0] mag, logic neg,
                               logic [MINCNT_W-1:0] cnt, logic grp);
        i_valid           <= 1'b1;
        i_magnitude       <= mag;
        i_negative        <= neg;
        i_min_digit_count <= cnt;
        i_group_thousands <= grp;
        @(posedge i_clk);
        while (!(i_valid && o_ready))
            @(posedge i_clk);
        numbers_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 150)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                    : $urandom_range(1, 6);
        end
    endtask

    // random number: full width, shifted, small, or near a power of ten
    task automatic send_random_number();
        logic [MAG_W-1:0]    m;
        logic [MINCNT_W-1:0] cnt;
        int                  k;
        case ($urandom_range(0, 3))
            0: m = {$urandom, $urandom};
            1: m = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: m = MAG_W'($urandom_range(0, 9999));
            default: begin
                m = 64'd1;
                k = $urandom_range(0, 19);
                repeat (k) m = m * 10;
                case ($urandom_range(0, 2))
                    0: m = m - 1;
                    1: m = m + 1;
                    default: ;
                endcase
            end
        endcase
        cnt = ($urandom_range(0, 3) == 0) ? MINCNT_W'($urandom_range(0, 63))
                                          : MINCNT_W'($urandom_range(0, 24));
        send_number(m, 1'($urandom), cnt, 1'($urandom));
    endtask

    // receiver stall pattern, with one long hold-off to back up the block
    initial begin
        int seg;
        int len;
        int mode;
        seg     = 0;
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            mode = (seg == 3) ? 3 : $urandom_range(0, 2);
            len  = (mode == 3) ? LONG_HOLD : $urandom_range(10, 200);
            repeat (len) begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= 1'b0;
                endcase
                @(posedge i_clk);
            end
            seg++;
        end
    end

    // end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_magnitude       = '0;
        i_negative        = 1'b0;
        i_min_digit_count = '0;
        i_group_thousands = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero, negative zero, padding and its saturation
        send_number(64'd0, 1'b0, 6'd0, 1'b0);
        send_number(64'd0, 1'b1, 6'd0, 1'b0);
        send_number(64'd0, 1'b0, 6'd32, 1'b0);
        send_number(64'd0, 1'b1, 6'd63, 1'b0);
        send_number(64'd7, 1'b0, 6'd33, 1'b0);
        // widest values
        send_number({MAG_W{1'b1}}, 1'b0, 6'd0, 1'b0);
        send_number({MAG_W{1'b1}}, 1'b1, 6'd63, 1'b1);
        send_number(64'h8000_0000_0000_0000, 1'b1, 6'd20, 1'b0);
        send_number(64'd10_000_000_000_000_000_000, 1'b0, 6'd20, 1'b0);
        send_number(64'd9_999_999_999_999_999_999, 1'b1, 6'd21, 1'b0);
        // padding around the digit count
        send_number(64'd12345, 1'b0, 6'd4, 1'b0);
        send_number(64'd12345, 1'b0, 6'd5, 1'b0);
        send_number(64'd12345, 1'b1, 6'd6, 1'b0);
        // grouping boundaries, count ignored
        send_number(64'd0, 1'b1, 6'd10, 1'b1);
        send_number(64'd1, 1'b0, 6'd5, 1'b1);
        send_number(64'd99, 1'b1, 6'd0, 1'b1);
        send_number(64'd999, 1'b0, 6'd0, 1'b1);
        send_number(64'd1000, 1'b0, 6'd33, 1'b1);
        send_number(64'd1234, 1'b1, 6'd40, 1'b1);
        send_number(64'd999999, 1'b0, 6'd0, 1'b1);
        send_number(64'd1000000, 1'b0, 6'd63, 1'b1);
        directed_sent = numbers_sent;

        repeat (RANDOM_ITEMS) send_random_number();
        i_valid <= 1'b0;

        // wait for the last character, then let the block settle
        @(posedge i_clk);
        while (pending_chars != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d numbers (%0d directed: zero, negative zero, %s)",
                 numbers_sent, directed_sent, "padding limits, grouping");
        $display("compared %0d characters under random input gaps and output stalls",
                 chars_checked);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
